// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/tad_pkg.sv
// ---------------------------------------------------------------------------
// tad_pkg
// types and constants shared by the tar stream deframer
// ---------------------------------------------------------------------------
package tad_pkg;

   // byte kind codes on the result channel
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_DATA   = 3'd1;
   localparam logic [2:0] KIND_PAD    = 3'd2;
   localparam logic [2:0] KIND_SKIP   = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   // header layout
   localparam logic [8:0] OFF_FIRST    = 9'd0;
   localparam logic [8:0] OFF_MODE_LO  = 9'd100;
   localparam logic [8:0] OFF_MODE_HI  = 9'd107;
   localparam logic [8:0] OFF_SIZE_LO  = 9'd124;
   localparam logic [8:0] OFF_SIZE_HI  = 9'd135;
   localparam logic [8:0] OFF_TYPE     = 9'd156;
   localparam logic [8:0] OFF_PREFIX   = 9'd345;
   localparam logic [8:0] BLOCK_LAST   = 9'd511;

   localparam logic [7:0] TYPE_DIR     = 8'h35;
   localparam logic [7:0] TYPE_REG     = 8'h30;
   localparam logic [7:0] TYPE_REG_OLD = 8'h00;
   localparam logic [4:0] OCTAL_HIGH   = 5'b00110;

   localparam int SIZE_OUT_BITS = 36;
   localparam int MODE_BITS     = 24;
   localparam logic [MODE_BITS-1:0] MODE_DEFAULT = 24'o755;

   typedef enum logic [1:0] {
      CLASS_DIR   = 2'd0,
      CLASS_REG   = 2'd1,
      CLASS_OTHER = 2'd2
   } class_type;

   typedef struct packed {
      logic [7:0]               out_byte;
      logic [2:0]               byte_kind;
      logic                     entry_ready;
      class_type                entry_type;
      logic [SIZE_OUT_BITS-1:0] entry_size;
      logic [MODE_BITS-1:0]     entry_mode;
      logic [7:0]               entry_typeflag;
      logic                     archive_end;
   } result_type;

   function automatic class_type entry_class(input logic [7:0] flag);
      class_type cls;
      if (flag == TYPE_DIR) begin
         cls = CLASS_DIR;
      end else if (flag == TYPE_REG || flag == TYPE_REG_OLD) begin
         cls = CLASS_REG;
      end else begin
         cls = CLASS_OTHER;
      end
      return cls;
   endfunction

endpackage

// File: rtl/tad_parse.sv
// ---------------------------------------------------------------------------
// tad_parse
// per-byte header parser and content counter, one word per cycle while advance is high
// ---------------------------------------------------------------------------
module tad_parse #(
   parameter int SIZE_FIELD_BITS = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            req_byte,
   output tad_pkg::result_type   result
);

   typedef enum logic [2:0] {
      PH_HEADER = tad_pkg::KIND_HEADER,
      PH_DATA   = tad_pkg::KIND_DATA,
      PH_PAD    = tad_pkg::KIND_PAD,
      PH_SKIP   = tad_pkg::KIND_SKIP,
      PH_END    = tad_pkg::KIND_END
   } phase_type;

   localparam int SW = SIZE_FIELD_BITS;

   phase_type                      phase_ff, phase_in;
   logic [8:0]                     offset_ff, offset_in;
   logic [SW:0]                    left_ff, left_in;
   logic [SW-1:0]                  size_ff, size_in;
   logic                           size_stop_ff, size_stop_in;
   logic [tad_pkg::MODE_BITS-1:0]  mode_ff, mode_in;
   logic                           mode_stop_ff, mode_stop_in;
   logic [7:0]                     type_ff, type_in;
   logic                           nul_ff, nul_in;

   logic                           octal;
   logic [2:0]                     digit;
   logic [SW:0]                    left_dec;
   logic [8:0]                     pad;
   logic [SW:0]                    round_up;
   logic                           entry_ready;
   logic                           archive_end;

   always_comb begin
      octal    = (req_byte[7:3] == tad_pkg::OCTAL_HIGH);
      digit    = req_byte[2:0];
      left_dec = (left_ff != '0) ? (left_ff - 1'b1) : left_ff;
      pad      = (~size_ff[8:0]) + 9'd1;
      round_up = {1'b0, size_ff} + {{(SW-8){1'b0}}, tad_pkg::BLOCK_LAST};

      phase_in     = phase_ff;
      offset_in    = offset_ff;
      left_in      = left_ff;
      size_in      = size_ff;
      size_stop_in = size_stop_ff;
      mode_in      = mode_ff;
      mode_stop_in = mode_stop_ff;
      type_in      = type_ff;
      nul_in       = nul_ff;
      entry_ready  = 1'b0;
      archive_end  = 1'b0;

      if (advance) begin
         case (phase_ff)
            PH_HEADER: begin
               if (offset_ff == tad_pkg::OFF_FIRST) begin
                  size_in      = '0;
                  size_stop_in = 1'b0;
                  mode_in      = '0;
                  mode_stop_in = 1'b0;
                  type_in      = '0;
                  nul_in       = (req_byte == 8'd0);
               end
               if (offset_ff == tad_pkg::OFF_PREFIX) begin
                  nul_in = nul_ff && (req_byte == 8'd0);
               end
               if (offset_ff >= tad_pkg::OFF_MODE_LO && offset_ff <= tad_pkg::OFF_MODE_HI
                   && !mode_stop_ff) begin
                  if (octal) begin
                     mode_in = {mode_ff[tad_pkg::MODE_BITS-4:0], digit};
                  end else begin
                     mode_stop_in = 1'b1;
                  end
               end
               if (offset_ff >= tad_pkg::OFF_SIZE_LO && offset_ff <= tad_pkg::OFF_SIZE_HI
                   && !size_stop_ff) begin
                  if (octal) begin
                     size_in = {size_ff[SW-4:0], digit};
                  end else begin
                     size_stop_in = 1'b1;
                  end
               end
               if (offset_ff == tad_pkg::OFF_TYPE) begin
                  type_in = req_byte;
               end
               if (offset_ff == tad_pkg::BLOCK_LAST) begin
                  offset_in = '0;
                  if (nul_ff) begin
                     phase_in    = PH_END;
                     archive_end = 1'b1;
                  end else begin
                     entry_ready = 1'b1;
                     case (tad_pkg::entry_class(type_ff))
                        tad_pkg::CLASS_DIR: begin
                           phase_in = PH_HEADER;
                           left_in  = '0;
                        end
                        tad_pkg::CLASS_REG: begin
                           left_in  = {1'b0, size_ff};
                           phase_in = (size_ff != '0) ? PH_DATA : PH_HEADER;
                        end
                        default: begin
                           left_in  = {round_up[SW:9], 9'd0};
                           phase_in = (round_up[SW:9] != '0) ? PH_SKIP : PH_HEADER;
                        end
                     endcase
                  end
               end else begin
                  offset_in = offset_ff + 9'd1;
               end
            end
            PH_DATA: begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  left_in  = {{(SW-8){1'b0}}, pad};
                  phase_in = (pad != 9'd0) ? PH_PAD : PH_HEADER;
               end
            end
            PH_PAD, PH_SKIP: begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // result kind follows the phase before this word; entry fields the state after it
      result.out_byte    = req_byte;
      result.byte_kind   = phase_ff;
      result.entry_ready = entry_ready;
      result.archive_end = archive_end;
      if (phase_ff == PH_END) begin
         result.entry_type     = tad_pkg::CLASS_DIR;
         result.entry_size     = '0;
         result.entry_mode     = '0;
         result.entry_typeflag = '0;
      end else begin
         result.entry_type     = tad_pkg::entry_class(type_in);
         result.entry_size     = tad_pkg::SIZE_OUT_BITS'(size_in);
         result.entry_mode     = (mode_in == '0) ? tad_pkg::MODE_DEFAULT : mode_in;
         result.entry_typeflag = type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         offset_ff    <= '0;
         left_ff      <= '0;
         size_ff      <= '0;
         size_stop_ff <= 1'b0;
         mode_ff      <= '0;
         mode_stop_ff <= 1'b0;
         type_ff      <= '0;
         nul_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         left_ff      <= left_in;
         size_ff      <= size_in;
         size_stop_ff <= size_stop_in;
         mode_ff      <= mode_in;
         mode_stop_ff <= mode_stop_in;
         type_ff      <= type_in;
         nul_ff       <= nul_in;
      end
   end

endmodule

// File: rtl/tad_out_stage.sv
// ---------------------------------------------------------------------------
// tad_out_stage
// result register with valid/ready handshake
// ---------------------------------------------------------------------------
module tad_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 take,
   input  tad_pkg::result_type  in_result,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tad_pkg::result_type  out_result
);

   logic                 valid_ff, valid_in;
   tad_pkg::result_type  result_ff;

   // load whenever the register is empty or being drained
   assign in_ready   = !valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign valid_in   = take || (valid_ff && !out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= in_result;
      end
   end

endmodule

// File: rtl/tar_archive_stream_deframer.sv
// ---------------------------------------------------------------------------
// tar_archive_stream_deframer
// classifies every byte of a ustar archive stream and reports entry headers
// ---------------------------------------------------------------------------
//  channel | ports                      | dir | carries
//  --------+----------------------------+-----+--------------------------------
//  req     | req_valid/ready, req_in_byte | in  | one archive byte per word
//  rsp     | rsp_valid/ready, rsp_*       | out | byte, kind and entry fields
//
//  one word per clock while rsp is not stalled: the parser state updates as a
//  word is taken and the result lands in the output register on the same edge
//  rsp_valid is registered and rises in the cycle after req acceptance
//  reset (synchronous) returns to the first byte of a header block
//  a stalled rsp holds its word; req_ready stays high while rsp is drained
// ---------------------------------------------------------------------------
module tar_archive_stream_deframer #(
   parameter int SIZE_FIELD_BITS = 36
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_byte_kind,
   output logic        rsp_entry_ready,
   output logic [1:0]  rsp_entry_type,
   output logic [35:0] rsp_entry_size,
   output logic [23:0] rsp_entry_mode,
   output logic [7:0]  rsp_entry_typeflag,
   output logic        rsp_archive_end
);

   logic                 take;
   tad_pkg::result_type  next_result;
   tad_pkg::result_type  held_result;

   // header parsing, content counting and classification
   tad_parse #(
      .SIZE_FIELD_BITS (SIZE_FIELD_BITS)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .advance  (take),
      .req_byte (req_in_byte),
      .result   (next_result)
   );

   // output register, decouples the two handshakes
   tad_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .take       (take),
      .in_result  (next_result),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (held_result)
   );

   // unpack the held word onto the result ports
   assign rsp_out_byte       = held_result.out_byte;
   assign rsp_byte_kind      = held_result.byte_kind;
   assign rsp_entry_ready    = held_result.entry_ready;
   assign rsp_entry_type     = held_result.entry_type;
   assign rsp_entry_size     = held_result.entry_size;
   assign rsp_entry_mode     = held_result.entry_mode;
   assign rsp_entry_typeflag = held_result.entry_typeflag;
   assign rsp_archive_end    = held_result.archive_end;

endmodule

// File: rtl/tad_checker.sv
// ---------------------------------------------------------------------------
// tad_checker
// port-level checks for the tar stream deframer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic [2:0]  rsp_byte_kind,
   input logic        rsp_entry_ready,
   input logic [1:0]  rsp_entry_type,
   input logic [35:0] rsp_entry_size,
   input logic [23:0] rsp_entry_mode,
   input logic [7:0]  rsp_entry_typeflag,
   input logic        rsp_archive_end
);

   logic rsp_stall;
   logic rsp_marked;
   logic rsp_on_header;
   logic rsp_after_end;
   logic rsp_live;
   logic fields_clear;

   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_marked    = rsp_valid && (rsp_entry_ready || rsp_archive_end);
   assign rsp_on_header = (rsp_byte_kind == tad_pkg::KIND_HEADER);
   assign rsp_after_end = rsp_valid && (rsp_byte_kind == tad_pkg::KIND_END);
   assign rsp_live      = rsp_valid && (rsp_byte_kind != tad_pkg::KIND_END);
   assign fields_clear  = (rsp_entry_size == '0) && (rsp_entry_mode == '0)
                          && (rsp_entry_typeflag == '0)
                          && (rsp_entry_type == tad_pkg::CLASS_DIR);

   // a stalled word stays put
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_stall |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_byte_kind)))

   // draining the output always frees the input side
   `ASSERT_CLK(a_ready_on_drain, clock, rsp_ready |-> req_ready)

   // entry and end markers only come on header bytes, never together
   `ASSERT_CLK_RST(a_marks_on_header, clock, reset,
      rsp_marked |-> (rsp_on_header && !(rsp_entry_ready && rsp_archive_end)))

   // after the end every entry field reads zero
   `ASSERT_CLK_RST(a_end_clears, clock, reset, rsp_after_end |-> fields_clear)

   // before the end the mode never reads zero
   `ASSERT_CLK_RST(a_mode_nonzero, clock, reset, rsp_live |-> (rsp_entry_mode != '0))

endmodule

bind tar_archive_stream_deframer tad_checker u_tad_checker (.*);

// File: tb/sv/tar_archive_stream_deframer_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tar_archive_stream_deframer_check
// watches the byte and result channels, tags every accepted byte the way the
// deframer should and compares each returned word field by field
// ---------------------------------------------------------------------------
module tar_archive_stream_deframer_check #(
   parameter int SIZE_BITS = 36
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic [2:0]  rsp_byte_kind,
   input  logic        rsp_entry_ready,
   input  logic [1:0]  rsp_entry_type,
   input  logic [35:0] rsp_entry_size,
   input  logic [23:0] rsp_entry_mode,
   input  logic [7:0]  rsp_entry_typeflag,
   input  logic        rsp_archive_end,
   output int          mismatches,
   output int          pending
);

   localparam logic [35:0] SIZE_KEEP =
      (SIZE_BITS >= 36) ? {36{1'b1}} : ((36'd1 << SIZE_BITS) - 36'd1);

   // parser state
   logic [8:0]  offset_in_block;
   logic [2:0]  cur_phase;
   logic [36:0] remaining;
   logic [35:0] size_value;
   logic        size_done;
   logic [23:0] mode_value;
   logic        mode_done;
   logic [7:0]  flag_byte;
   logic        name_nul;
   logic        past_end;

   tad_pkg::result_type due_words[$];
   int fail_count = 0;

   assign mismatches = fail_count;

   function automatic tad_pkg::class_type flag_group(input logic [7:0] f);
      case (f)
         tad_pkg::TYPE_DIR:                        return tad_pkg::CLASS_DIR;
         tad_pkg::TYPE_REG, tad_pkg::TYPE_REG_OLD: return tad_pkg::CLASS_REG;
         default:                                  return tad_pkg::CLASS_OTHER;
      endcase
   endfunction

   // advance the parser by one byte and give the word it should produce
   task automatic classify_byte(input logic [7:0] b, output tad_pkg::result_type r);
      logic [2:0] kind;
      logic [8:0] pad;
      logic       ready_bit;
      logic       end_bit;
      kind      = past_end ? tad_pkg::KIND_END : cur_phase;
      ready_bit = 1'b0;
      end_bit   = 1'b0;
      case (kind)
         tad_pkg::KIND_HEADER: begin
            if (offset_in_block == tad_pkg::OFF_FIRST) begin
               size_value = '0;
               size_done  = 1'b0;
               mode_value = '0;
               mode_done  = 1'b0;
               flag_byte  = '0;
               name_nul   = (b == 8'h00);
            end
            if (offset_in_block == tad_pkg::OFF_PREFIX) name_nul = name_nul && (b == 8'h00);
            if (offset_in_block >= tad_pkg::OFF_MODE_LO
                  && offset_in_block <= tad_pkg::OFF_MODE_HI && !mode_done) begin
               if (b[7:3] == tad_pkg::OCTAL_HIGH) mode_value = {mode_value[20:0], b[2:0]};
               else mode_done = 1'b1;
            end
            if (offset_in_block >= tad_pkg::OFF_SIZE_LO
                  && offset_in_block <= tad_pkg::OFF_SIZE_HI && !size_done) begin
               if (b[7:3] == tad_pkg::OCTAL_HIGH)
                  size_value = {size_value[32:0], b[2:0]} & SIZE_KEEP;
               else size_done = 1'b1;
            end
            if (offset_in_block == tad_pkg::OFF_TYPE) flag_byte = b;
            if (offset_in_block == tad_pkg::BLOCK_LAST) begin
               offset_in_block = tad_pkg::OFF_FIRST;
               if (name_nul) begin
                  past_end = 1'b1;
                  end_bit  = 1'b1;
               end else begin
                  ready_bit = 1'b1;
                  case (flag_group(flag_byte))
                     tad_pkg::CLASS_DIR: begin
                        remaining = '0;
                        cur_phase = tad_pkg::KIND_HEADER;
                     end
                     tad_pkg::CLASS_REG: begin
                        remaining = {1'b0, size_value};
                        cur_phase = (size_value != 0) ? tad_pkg::KIND_DATA
                                                      : tad_pkg::KIND_HEADER;
                     end
                     default: begin
                        remaining = ({1'b0, size_value} + 37'(tad_pkg::BLOCK_LAST))
                                    & ~37'(tad_pkg::BLOCK_LAST);
                        cur_phase = (remaining != 0) ? tad_pkg::KIND_SKIP
                                                     : tad_pkg::KIND_HEADER;
                     end
                  endcase
               end
            end else begin
               offset_in_block = offset_in_block + 9'd1;
            end
         end
         tad_pkg::KIND_DATA: begin
            if (remaining != 0) remaining = remaining - 37'd1;
            if (remaining == 0) begin
               pad       = 9'd0 - size_value[8:0];
               remaining = 37'(pad);
               cur_phase = (pad != 0) ? tad_pkg::KIND_PAD : tad_pkg::KIND_HEADER;
            end
         end
         tad_pkg::KIND_PAD, tad_pkg::KIND_SKIP: begin
            if (remaining != 0) remaining = remaining - 37'd1;
            if (remaining == 0) cur_phase = tad_pkg::KIND_HEADER;
         end
         default: ;
      endcase

      r.out_byte    = b;
      r.byte_kind   = kind;
      r.entry_ready = ready_bit;
      r.archive_end = end_bit;
      if (kind == tad_pkg::KIND_END) begin
         r.entry_type     = tad_pkg::CLASS_DIR;
         r.entry_size     = '0;
         r.entry_mode     = '0;
         r.entry_typeflag = '0;
      end else begin
         r.entry_type     = flag_group(flag_byte);
         r.entry_size     = size_value & SIZE_KEEP;
         r.entry_mode     = (mode_value == 0) ? tad_pkg::MODE_DEFAULT : mode_value;
         r.entry_typeflag = flag_byte;
      end
   endtask

   task automatic check_field(input string field, input logic [35:0] want,
                              input logic [35:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tad_pkg::result_type want;
      if (reset) begin
         offset_in_block = tad_pkg::OFF_FIRST;
         cur_phase       = tad_pkg::KIND_HEADER;
         remaining       = '0;
         size_value      = '0;
         size_done       = 1'b0;
         mode_value      = '0;
         mode_done       = 1'b0;
         flag_byte       = '0;
         name_nul        = 1'b0;
         past_end        = 1'b0;
         due_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               $error("unexpected word: out_byte %0d, byte_kind %0d",
                      rsp_out_byte, rsp_byte_kind);
               fail_count++;
            end else begin
               want = due_words.pop_front();
               check_field("out_byte", 36'(want.out_byte), 36'(rsp_out_byte));
               check_field("byte_kind", 36'(want.byte_kind), 36'(rsp_byte_kind));
               check_field("entry_ready", 36'(want.entry_ready), 36'(rsp_entry_ready));
               check_field("entry_type", 36'(want.entry_type), 36'(rsp_entry_type));
               check_field("entry_size", want.entry_size, rsp_entry_size);
               check_field("entry_mode", 36'(want.entry_mode), 36'(rsp_entry_mode));
               check_field("entry_typeflag", 36'(want.entry_typeflag),
                           36'(rsp_entry_typeflag));
               check_field("archive_end", 36'(want.archive_end), 36'(rsp_archive_end));
            end
         end
         if (req_valid && req_ready) begin
            classify_byte(req_in_byte, want);
            due_words.insert(due_words.size(), want);
         end
      end
      pending <= due_words.size();
   end

endmodule

// File: tb/sv/tar_archive_stream_deframer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tar_archive_stream_deframer_tb
// feeds a tar archive byte by byte through the deframer and gives the verdict
// from the checker's mismatch count; one entry is built as a real header block
// with random contents, broken numeric fields and random idling on both sides
// ---------------------------------------------------------------------------
module tar_archive_stream_deframer_tb;

   localparam int SIZE_FIELD_BITS = 36;
   localparam int unsigned CYCLE_LIMIT = 300_000;
   localparam int MODE_DIGITS = tad_pkg::OFF_MODE_HI - tad_pkg::OFF_MODE_LO + 1;
   localparam int SIZE_DIGITS = tad_pkg::OFF_SIZE_HI - tad_pkg::OFF_SIZE_LO + 1;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_byte_kind;
   logic        rsp_entry_ready;
   logic [1:0]  rsp_entry_type;
   logic [35:0] rsp_entry_size;
   logic [23:0] rsp_entry_mode;
   logic [7:0]  rsp_entry_typeflag;
   logic        rsp_archive_end;

   int          mismatches;
   int          due_left;
   int unsigned cycle_count = 0;

   // calm stretches: no idling on that side while set
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;

   // one header block under construction
   logic [7:0] block_bytes [512];

   always #6 clock = ~clock;

   tar_archive_stream_deframer #(
      .SIZE_FIELD_BITS(SIZE_FIELD_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_kind     (rsp_byte_kind),
      .rsp_entry_ready   (rsp_entry_ready),
      .rsp_entry_type    (rsp_entry_type),
      .rsp_entry_size    (rsp_entry_size),
      .rsp_entry_mode    (rsp_entry_mode),
      .rsp_entry_typeflag(rsp_entry_typeflag),
      .rsp_archive_end   (rsp_archive_end)
   );

   tar_archive_stream_deframer_check #(
      .SIZE_BITS(SIZE_FIELD_BITS)
   ) deframe_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_kind     (rsp_byte_kind),
      .rsp_entry_ready   (rsp_entry_ready),
      .rsp_entry_type    (rsp_entry_type),
      .rsp_entry_size    (rsp_entry_size),
      .rsp_entry_mode    (rsp_entry_mode),
      .rsp_entry_typeflag(rsp_entry_typeflag),
      .rsp_archive_end   (rsp_archive_end),
      .mismatches        (mismatches),
      .pending           (due_left)
   );

   // watchdog: a hung handshake or a lost word ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // any byte whose top five bits do not make it an octal digit
   function automatic logic [7:0] non_octal();
      logic [7:0] b;
      do b = 8'($urandom); while (b[7:3] == tad_pkg::OCTAL_HIGH);
      return b;
   endfunction

   // one word on the byte channel, after a random gap with valid low
   task automatic send_word(input logic [7:0] b);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // header block with random filler, then the content the entry implies
   // numeric fields carry the given number of octal digits, then the stop byte if room is left
   task automatic send_entry(input logic [7:0] name0, input logic [7:0] prefix0,
                             input logic [7:0] flag, input logic [23:0] mode,
                             input int mode_digits, input logic [35:0] entry_len,
                             input int len_digits, input logic [7:0] stop);
      longint unsigned parsed_len;
      longint unsigned mode_kept;
      longint unsigned tail;
      longint unsigned k;
      int i;
      parsed_len = 64'(entry_len) & ((64'd1 << (3 * len_digits)) - 64'd1);
      mode_kept  = 64'(mode) & ((64'd1 << (3 * mode_digits)) - 64'd1);
      for (i = 0; i < 512; i++) block_bytes[i] = 8'($urandom);
      block_bytes[tad_pkg::OFF_FIRST]  = name0;
      block_bytes[tad_pkg::OFF_PREFIX] = prefix0;
      block_bytes[tad_pkg::OFF_TYPE]   = flag;
      for (i = 0; i < mode_digits; i++) begin
         block_bytes[tad_pkg::OFF_MODE_LO + i] =
            DIGIT_ZERO | 8'((mode_kept >> (3 * (mode_digits - 1 - i))) & 64'd7);
      end
      if (mode_digits < MODE_DIGITS) block_bytes[tad_pkg::OFF_MODE_LO + mode_digits] = stop;
      for (i = 0; i < len_digits; i++) begin
         block_bytes[tad_pkg::OFF_SIZE_LO + i] =
            DIGIT_ZERO | 8'((parsed_len >> (3 * (len_digits - 1 - i))) & 64'd7);
      end
      if (len_digits < SIZE_DIGITS) block_bytes[tad_pkg::OFF_SIZE_LO + len_digits] = stop;
      for (i = 0; i < 512; i++) send_word(block_bytes[i]);
      // files and skipped types both occupy the length rounded up to a block
      tail = (flag == tad_pkg::TYPE_DIR) ? 64'd0 : ((parsed_len + 64'd511) & ~64'd511);
      for (k = 0; k < tail; k++) send_word(8'($urandom));
   endtask

   // receiver: random stall before each word, with calm stretches now and then
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 99) == 0) take_calm = !take_calm;
         stall = take_calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int n;
      int pick;
      int mode_digits;
      int len_digits;
      logic [7:0]  flag;
      logic [7:0]  name0;
      logic [23:0] mode;
      logic [35:0] entry_len;

      req_valid   <= 1'b0;
      req_in_byte <= 8'h00;
      reset       <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one entry of random type, content kept within a single block
      send_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         flag = tad_pkg::TYPE_REG;
      end else if (pick == 3) begin
         flag = tad_pkg::TYPE_REG_OLD;
      end else if (pick < 6) begin
         flag = tad_pkg::TYPE_DIR;
      end else begin
         do flag = 8'($urandom);
         while (flag == tad_pkg::TYPE_REG || flag == tad_pkg::TYPE_REG_OLD
                || flag == tad_pkg::TYPE_DIR);
      end
      if (flag == tad_pkg::TYPE_DIR) begin
         entry_len = {4'($urandom), 32'($urandom)};
      end else begin
         case ($urandom_range(0, 4))
            0:       entry_len = 36'd0;
            1:       entry_len = 36'd1;
            2:       entry_len = 36'd511;
            3:       entry_len = 36'd512;
            default: entry_len = 36'($urandom_range(2, 510));
         endcase
      end
      len_digits  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(4, SIZE_DIGITS);
      mode        = ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom);
      mode_digits = $urandom_range(0, MODE_DIGITS);
      name0       = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_entry(name0, (name0 == 8'h00) ? 8'($urandom_range(1, 255)) : 8'($urandom),
                 flag, mode, mode_digits, entry_len, len_digits, non_octal());

      // all-zero block ends the archive; whatever follows is after the end
      send_calm = 1'b0;
      for (n = 0; n < 512; n++) send_word(8'h00);
      for (n = 0; n < 16; n++) send_word(8'($urandom));
      send_word(8'h00);
      send_word(8'hff);
      req_valid <= 1'b0;

      // drain, then keep watching for anything stray behind the last word
      @(posedge clock);
      while (due_left != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
